// ----- rtl/lbc_pkg.sv -----
// Shared constants, widths and types for the line to image border clipper.
// No dependencies; used by every module under rtl/.
package lbc_pkg;

    localparam int FRAC_BITS = 8;
    localparam int IN_W      = 24;
    localparam int CFG_W     = 15;
    localparam int COORD_W   = CFG_W + FRAC_BITS;
    localparam int DIFF_W    = IN_W + 1;
    localparam int PROD_W    = DIFF_W + IN_W;
    localparam int NUM_W     = PROD_W + 2;
    localparam int CNT_W     = 3;
    localparam int SQ_W      = 2 * DIFF_W;
    localparam int DIST_W    = SQ_W + 1;
    localparam int NSIDES    = 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int DIV_LAT     = COORD_W + 2;

    localparam int IN_TDATA_W  = ((4 * IN_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = CNT_W + 4 * COORD_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    localparam int SIDE_LEFT   = 0;
    localparam int SIDE_RIGHT  = 1;
    localparam int SIDE_TOP    = 2;
    localparam int SIDE_BOTTOM = 3;

    typedef struct packed {
        logic signed [NUM_W-1:0]  n0;
        logic signed [NUM_W-1:0]  n1;
        logic signed [NUM_W-1:0]  n2;
        logic signed [NUM_W-1:0]  n3;
        logic signed [DIFF_W-1:0] a;
        logic signed [DIFF_W-1:0] b;
        logic signed [IN_W-1:0]   x1;
        logic signed [IN_W-1:0]   y1;
    } lbc_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } lbc_qstat_t;

endpackage

// ----- rtl/line_image_border_clip.sv -----
// Top level of the line to image border clipper: config registers and stream ports.
// Depends on lbc_pkg, lbc_front, lbc_queue, lbc_back.
//
// Each input beat carries two points of a line (signed, 8 fraction bits); each output
// beat gives the two image border crossings, nearer one first, plus a valid flag in
// tuser and the crossing count. One beat is accepted per clock while the output is
// taken; a beat passes the front registers, the job queue, the four pipelined side
// dividers (one quotient bit per stage) and the selection, distance and output
// registers. The user must write width and height on the cfg port only while no
// beat is in flight; the block itself does not enforce this.
module line_image_border_clip #(
    parameter int QUEUE_DEPTH = lbc_pkg::QUEUE_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [lbc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [lbc_pkg::CFG_W-1:0]           cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // first_x, first_y, second_x, second_y
    input  logic [lbc_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // crossings, near_x, near_y, far_x, far_y, zero pad
    output logic [lbc_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // valid_res
    output logic                                m_tuser
);

    localparam int IN_W = lbc_pkg::IN_W;
    localparam int CW   = lbc_pkg::COORD_W;

    logic [lbc_pkg::CFG_W-1:0] img_w_reg, img_h_reg;
    logic                      push, pop;
    lbc_pkg::lbc_job_t         job_f, job_q;
    lbc_pkg::lbc_qstat_t       qstat;
    logic [lbc_pkg::CNT_W-1:0] crossings;
    logic [CW-1:0]             near_x, near_y, far_x, far_y;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            img_w_reg <= lbc_pkg::WIDTH_RESET;
            img_h_reg <= lbc_pkg::HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                lbc_pkg::REG_IMAGE_WIDTH: begin
                    img_w_reg <= cfg_wr_data;
                end
                lbc_pkg::REG_IMAGE_HEIGHT: begin
                    img_h_reg <= cfg_wr_data;
                end
                default: begin
                end
            endcase
        end
    end

    lbc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .img_w    (img_w_reg),
        .img_h    (img_h_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .x1       ($signed(s_tdata[IN_W-1:0])),
        .y1       ($signed(s_tdata[2*IN_W-1:IN_W])),
        .x2       ($signed(s_tdata[3*IN_W-1:2*IN_W])),
        .y2       ($signed(s_tdata[4*IN_W-1:3*IN_W])),
        .qstat    (qstat),
        .push     (push),
        .job      (job_f)
    );

    lbc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .job_in  (job_f),
        .pop     (pop),
        .job_out (job_q),
        .qstat   (qstat)
    );

    lbc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .img_w     (img_w_reg),
        .img_h     (img_h_reg),
        .qstat     (qstat),
        .job       (job_q),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .valid_res (m_tuser),
        .crossings (crossings),
        .near_x    (near_x),
        .near_y    (near_y),
        .far_x     (far_x),
        .far_y     (far_y)
    );

    assign m_tdata = {{(lbc_pkg::OUT_TDATA_W - lbc_pkg::OUT_FIELD_W){1'b0}},
                      far_y, far_x, near_y, near_x, crossings};

endmodule

// ----- rtl/lbc_front.sv -----
// Front end: takes beats, forms the line equation and the four side numerators.
// Depends on lbc_pkg; feeds lbc_queue.
module lbc_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [lbc_pkg::CFG_W-1:0]         img_w,
    input  logic [lbc_pkg::CFG_W-1:0]         img_h,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [lbc_pkg::IN_W-1:0]   x1,
    input  logic signed [lbc_pkg::IN_W-1:0]   y1,
    input  logic signed [lbc_pkg::IN_W-1:0]   x2,
    input  logic signed [lbc_pkg::IN_W-1:0]   y2,
    input  lbc_pkg::lbc_qstat_t               qstat,
    output logic                              push,
    output lbc_pkg::lbc_job_t                 job
);

    localparam int DIFF_W = lbc_pkg::DIFF_W;
    localparam int PROD_W = lbc_pkg::PROD_W;
    localparam int NUM_W  = lbc_pkg::NUM_W;
    localparam int IN_W   = lbc_pkg::IN_W;

    logic en;
    logic v1_reg, v2_reg, v3_reg;
    logic signed [DIFF_W-1:0] a1_reg, b1_reg, a2_reg, b2_reg;
    logic signed [IN_W-1:0]   x1_s1_reg, y1_s1_reg, x1_s2_reg, y1_s2_reg;
    logic signed [PROD_W-1:0] pax_reg, pby_reg, par_reg, pbr_reg;
    logic signed [PROD_W-1:0] pax_next, pby_next, par_next, pbr_next;
    logic signed [DIFF_W-1:0] a1_next, b1_next;
    logic signed [IN_W:0]     rw_s, rh_s;
    logic signed [NUM_W-1:0]  negc;
    lbc_pkg::lbc_job_t        job_reg, job_next;

    assign en       = !v3_reg || !qstat.full;
    assign in_ready = en;
    assign push     = v3_reg && !qstat.full;
    assign job      = job_reg;

    assign rw_s = $signed({2'b00, img_w, {lbc_pkg::FRAC_BITS{1'b0}}});
    assign rh_s = $signed({2'b00, img_h, {lbc_pkg::FRAC_BITS{1'b0}}});

    always_comb begin
        a1_next  = DIFF_W'(y1) - DIFF_W'(y2);
        b1_next  = DIFF_W'(x2) - DIFF_W'(x1);
        pax_next = PROD_W'(a1_reg) * PROD_W'(x1_s1_reg);
        pby_next = PROD_W'(b1_reg) * PROD_W'(y1_s1_reg);
        par_next = PROD_W'(a1_reg) * PROD_W'(rw_s);
        pbr_next = PROD_W'(b1_reg) * PROD_W'(rh_s);
        negc        = NUM_W'(pax_reg) + NUM_W'(pby_reg);
        job_next.n0 = negc;
        job_next.n1 = negc - NUM_W'(par_reg);
        job_next.n2 = negc;
        job_next.n3 = negc - NUM_W'(pbr_reg);
        job_next.a  = a2_reg;
        job_next.b  = b2_reg;
        job_next.x1 = x1_s2_reg;
        job_next.y1 = y1_s2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg    <= a1_next;
            b1_reg    <= b1_next;
            x1_s1_reg <= x1;
            y1_s1_reg <= y1;
            pax_reg   <= pax_next;
            pby_reg   <= pby_next;
            par_reg   <= par_next;
            pbr_reg   <= pbr_next;
            a2_reg    <= a1_reg;
            b2_reg    <= b1_reg;
            x1_s2_reg <= x1_s1_reg;
            y1_s2_reg <= y1_s1_reg;
            job_reg   <= job_next;
        end
    end

endmodule

// ----- rtl/lbc_queue.sv -----
// Small FIFO of line jobs between the front end and the back end.
// Depends on lbc_pkg.
module lbc_queue #(
    parameter int DEPTH = lbc_pkg::QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  lbc_pkg::lbc_job_t    job_in,
    input  logic                 pop,
    output lbc_pkg::lbc_job_t    job_out,
    output lbc_pkg::lbc_qstat_t  qstat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lbc_pkg::lbc_job_t mem [0:DEPTH-1];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg, wr_ptr_next, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign qstat.full  = cnt_reg == CW'(DEPTH);
    assign qstat.empty = cnt_reg == '0;
    assign job_out     = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= job_in;
        end
    end

endmodule

// ----- rtl/lbc_div.sv -----
// Pipelined signed divider, truncating toward zero, one quotient bit per stage.
// Flags a zero divisor or a quotient too large for a coordinate. Depends on lbc_pkg.
module lbc_div (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [lbc_pkg::NUM_W-1:0]    num,
    input  logic signed [lbc_pkg::DIFF_W-1:0]   den,
    output logic [lbc_pkg::COORD_W-1:0]         quo,
    output logic                                neg,
    output logic                                bad
);

    localparam int NUM_W = lbc_pkg::NUM_W;
    localparam int DW    = lbc_pkg::DIFF_W;
    localparam int QW    = lbc_pkg::COORD_W;

    logic [NUM_W-1:0] nmag0_reg;
    logic [DW-1:0]    dmag0_reg;
    logic             neg0_reg, dz0_reg;

    logic [NUM_W-1:0] rem_reg  [0:QW-1];
    logic [DW-1:0]    dmag_reg [0:QW-1];
    logic [QW-1:0]    quo_reg  [0:QW];
    logic             neg_reg  [0:QW];
    logic             bad_reg  [0:QW];

    always_ff @(posedge aclk) begin
        if (en) begin
            nmag0_reg   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            dmag0_reg   <= den[DW-1] ? DW'(-den) : DW'(den);
            neg0_reg    <= num[NUM_W-1] ^ den[DW-1];
            dz0_reg     <= den == '0;
            rem_reg[0]  <= nmag0_reg;
            dmag_reg[0] <= dmag0_reg;
            quo_reg[0]  <= '0;
            neg_reg[0]  <= neg0_reg;
            bad_reg[0]  <= dz0_reg || (nmag0_reg >= (NUM_W'(dmag0_reg) << QW));
        end
    end

    for (genvar s = 0; s < QW; s++) begin : g_step
        localparam int K = QW - 1 - s;
        logic [NUM_W-1:0] trial;
        logic             ge;
        logic [QW-1:0]    quo_next;

        always_comb begin
            trial       = NUM_W'(dmag_reg[s]) << K;
            ge          = rem_reg[s] >= trial;
            quo_next    = quo_reg[s];
            quo_next[K] = ge;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[s+1] <= quo_next;
                neg_reg[s+1] <= neg_reg[s];
                bad_reg[s+1] <= bad_reg[s];
            end
        end

        if (s < QW - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[s+1]  <= ge ? rem_reg[s] - trial : rem_reg[s];
                    dmag_reg[s+1] <= dmag_reg[s];
                end
            end
        end
    end

    assign quo = quo_reg[QW];
    assign neg = neg_reg[QW];
    assign bad = bad_reg[QW];

endmodule

// ----- rtl/lbc_back.sv -----
// Back end: four side dividers, crossing selection, distance ordering, output register.
// Depends on lbc_pkg and lbc_div; fed from lbc_queue.
module lbc_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [lbc_pkg::CFG_W-1:0]         img_w,
    input  logic [lbc_pkg::CFG_W-1:0]         img_h,
    input  lbc_pkg::lbc_qstat_t               qstat,
    input  lbc_pkg::lbc_job_t                 job,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              valid_res,
    output logic [lbc_pkg::CNT_W-1:0]         crossings,
    output logic [lbc_pkg::COORD_W-1:0]       near_x,
    output logic [lbc_pkg::COORD_W-1:0]       near_y,
    output logic [lbc_pkg::COORD_W-1:0]       far_x,
    output logic [lbc_pkg::COORD_W-1:0]       far_y
);

    localparam int CW     = lbc_pkg::COORD_W;
    localparam int IN_W   = lbc_pkg::IN_W;
    localparam int DIFF_W = lbc_pkg::DIFF_W;
    localparam int SQ_W   = lbc_pkg::SQ_W;
    localparam int DIST_W = lbc_pkg::DIST_W;
    localparam int NS     = lbc_pkg::NSIDES;
    localparam int LAT    = lbc_pkg::DIV_LAT;
    localparam int CNT_W  = lbc_pkg::CNT_W;

    logic en;
    logic [CW-1:0] rw, rh;
    logic [CW-1:0] quo [0:NS-1];
    logic          neg [0:NS-1];
    logic          bad [0:NS-1];
    logic signed [lbc_pkg::NUM_W-1:0] nums [0:NS-1];
    logic signed [DIFF_W-1:0]         dens [0:NS-1];

    logic                   dv_reg [0:LAT-1];
    logic signed [IN_W-1:0] dx1_reg [0:LAT-1];
    logic signed [IN_W-1:0] dy1_reg [0:LAT-1];

    logic [NS-1:0]    ok;
    logic [CW-1:0]    cx [0:NS-1];
    logic [CW-1:0]    cy [0:NS-1];
    logic [CNT_W-1:0] nf;
    logic [CW-1:0]    px0_next, py0_next, px1_next, py1_next;

    logic                   s_v_reg;
    logic [CNT_W-1:0]       s_cnt_reg;
    logic [CW-1:0]          s_px0_reg, s_py0_reg, s_px1_reg, s_py1_reg;
    logic signed [IN_W-1:0] s_x1_reg, s_y1_reg;

    logic signed [DIFF_W-1:0] dx0, dy0, dx1, dy1;
    logic                     m_v_reg;
    logic [CNT_W-1:0]         m_cnt_reg;
    logic [CW-1:0]            m_px0_reg, m_py0_reg, m_px1_reg, m_py1_reg;
    logic signed [SQ_W-1:0]   sq0x_reg, sq0y_reg, sq1x_reg, sq1y_reg;

    logic                     a_v_reg;
    logic [CNT_W-1:0]         a_cnt_reg;
    logic [CW-1:0]            a_px0_reg, a_py0_reg, a_px1_reg, a_py1_reg;
    logic [DIST_W-1:0]        d0_reg, d1_reg;

    logic                     out_v_reg, out_res_reg, two, swap;
    logic [CNT_W-1:0]         out_cnt_reg;
    logic [CW-1:0]            out_nx_reg, out_ny_reg, out_fx_reg, out_fy_reg;

    assign en  = !out_v_reg || out_ready;
    assign pop = en && !qstat.empty;
    assign rw  = {img_w, {lbc_pkg::FRAC_BITS{1'b0}}};
    assign rh  = {img_h, {lbc_pkg::FRAC_BITS{1'b0}}};

    assign nums[lbc_pkg::SIDE_LEFT]   = job.n0;
    assign nums[lbc_pkg::SIDE_RIGHT]  = job.n1;
    assign nums[lbc_pkg::SIDE_TOP]    = job.n2;
    assign nums[lbc_pkg::SIDE_BOTTOM] = job.n3;
    assign dens[lbc_pkg::SIDE_LEFT]   = job.b;
    assign dens[lbc_pkg::SIDE_RIGHT]  = job.b;
    assign dens[lbc_pkg::SIDE_TOP]    = job.a;
    assign dens[lbc_pkg::SIDE_BOTTOM] = job.a;

    for (genvar i = 0; i < NS; i++) begin : g_div
        lbc_div u_div (
            .aclk (aclk),
            .en   (en),
            .num  (nums[i]),
            .den  (dens[i]),
            .quo  (quo[i]),
            .neg  (neg[i]),
            .bad  (bad[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < LAT; k++) begin
                dv_reg[k] <= 1'b0;
            end
        end else if (en) begin
            dv_reg[0] <= pop;
            for (int k = 1; k < LAT; k++) begin
                dv_reg[k] <= dv_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx1_reg[0] <= job.x1;
            dy1_reg[0] <= job.y1;
            for (int k = 1; k < LAT; k++) begin
                dx1_reg[k] <= dx1_reg[k-1];
                dy1_reg[k] <= dy1_reg[k-1];
            end
        end
    end

    // crossing coordinates per side; left/right test y against height, top/bottom x against width
    always_comb begin
        cx[lbc_pkg::SIDE_LEFT]   = '0;
        cy[lbc_pkg::SIDE_LEFT]   = quo[lbc_pkg::SIDE_LEFT];
        cx[lbc_pkg::SIDE_RIGHT]  = rw;
        cy[lbc_pkg::SIDE_RIGHT]  = quo[lbc_pkg::SIDE_RIGHT];
        cx[lbc_pkg::SIDE_TOP]    = quo[lbc_pkg::SIDE_TOP];
        cy[lbc_pkg::SIDE_TOP]    = '0;
        cx[lbc_pkg::SIDE_BOTTOM] = quo[lbc_pkg::SIDE_BOTTOM];
        cy[lbc_pkg::SIDE_BOTTOM] = rh;
        for (int i = 0; i < NS; i++) begin
            ok[i] = !bad[i] && (quo[i] == '0 || !neg[i]) &&
                    (quo[i] < ((i < lbc_pkg::SIDE_TOP) ? rh : rw));
        end
        nf       = '0;
        px0_next = '0;
        py0_next = '0;
        px1_next = '0;
        py1_next = '0;
        for (int i = 0; i < NS; i++) begin
            if (ok[i]) begin
                if (nf == CNT_W'(0)) begin
                    px0_next = cx[i];
                    py0_next = cy[i];
                end else if (nf == CNT_W'(1)) begin
                    px1_next = cx[i];
                    py1_next = cy[i];
                end
                nf = nf + 1'b1;
            end
        end
    end

    always_comb begin
        dx0 = DIFF_W'($signed({1'b0, s_px0_reg})) - DIFF_W'(s_x1_reg);
        dy0 = DIFF_W'($signed({1'b0, s_py0_reg})) - DIFF_W'(s_y1_reg);
        dx1 = DIFF_W'($signed({1'b0, s_px1_reg})) - DIFF_W'(s_x1_reg);
        dy1 = DIFF_W'($signed({1'b0, s_py1_reg})) - DIFF_W'(s_y1_reg);
        two  = a_cnt_reg == CNT_W'(2);
        swap = d0_reg > d1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_v_reg   <= 1'b0;
            m_v_reg   <= 1'b0;
            a_v_reg   <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (en) begin
            s_v_reg   <= dv_reg[LAT-1];
            m_v_reg   <= s_v_reg;
            a_v_reg   <= m_v_reg;
            out_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_cnt_reg <= nf;
            s_px0_reg <= px0_next;
            s_py0_reg <= py0_next;
            s_px1_reg <= px1_next;
            s_py1_reg <= py1_next;
            s_x1_reg  <= dx1_reg[LAT-1];
            s_y1_reg  <= dy1_reg[LAT-1];

            m_cnt_reg <= s_cnt_reg;
            m_px0_reg <= s_px0_reg;
            m_py0_reg <= s_py0_reg;
            m_px1_reg <= s_px1_reg;
            m_py1_reg <= s_py1_reg;
            sq0x_reg  <= SQ_W'(dx0) * SQ_W'(dx0);
            sq0y_reg  <= SQ_W'(dy0) * SQ_W'(dy0);
            sq1x_reg  <= SQ_W'(dx1) * SQ_W'(dx1);
            sq1y_reg  <= SQ_W'(dy1) * SQ_W'(dy1);

            a_cnt_reg <= m_cnt_reg;
            a_px0_reg <= m_px0_reg;
            a_py0_reg <= m_py0_reg;
            a_px1_reg <= m_px1_reg;
            a_py1_reg <= m_py1_reg;
            d0_reg    <= DIST_W'(sq0x_reg) + DIST_W'(sq0y_reg);
            d1_reg    <= DIST_W'(sq1x_reg) + DIST_W'(sq1y_reg);

            out_cnt_reg <= a_cnt_reg;
            out_res_reg <= two;
            out_nx_reg  <= !two ? '0 : (swap ? a_px1_reg : a_px0_reg);
            out_ny_reg  <= !two ? '0 : (swap ? a_py1_reg : a_py0_reg);
            out_fx_reg  <= !two ? '0 : (swap ? a_px0_reg : a_px1_reg);
            out_fy_reg  <= !two ? '0 : (swap ? a_py0_reg : a_py1_reg);
        end
    end

    assign out_valid = out_v_reg;
    assign valid_res = out_res_reg;
    assign crossings = out_cnt_reg;
    assign near_x    = out_nx_reg;
    assign near_y    = out_ny_reg;
    assign far_x     = out_fx_reg;
    assign far_y     = out_fy_reg;

    a_near_on_border: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_v_reg && out_res_reg) |->
        (out_nx_reg == '0 || out_nx_reg == rw || out_ny_reg == '0 || out_ny_reg == rh))
        else $error("near crossing not on image border");

    a_far_on_border: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_v_reg && out_res_reg) |->
        (out_fx_reg == '0 || out_fx_reg == rw || out_fy_reg == '0 || out_fy_reg == rh))
        else $error("far crossing not on image border");

    a_inside_rect: assert property (@(posedge aclk) disable iff (!aresetn)
        out_v_reg |-> (out_nx_reg <= rw && out_ny_reg <= rh &&
                       out_fx_reg <= rw && out_fy_reg <= rh))
        else $error("crossing outside image rectangle");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_v_reg |-> out_cnt_reg <= CNT_W'(lbc_pkg::NSIDES))
        else $error("crossing count above side count");

endmodule
